/* rtl/v3u_pkg.sv */
// Shared types, constants and tables for the 3D vector unit.
package v3u_pkg;

  // Word format of every vector component.
  localparam int WORD_BITS       = 32;
  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 16;

  // Operation codes carried in the action field.
  localparam int ACT_BITS = 4;
  localparam logic [ACT_BITS-1:0] ACT_ADD       = 4'd0;
  localparam logic [ACT_BITS-1:0] ACT_SUB       = 4'd1;
  localparam logic [ACT_BITS-1:0] ACT_DOT       = 4'd2;
  localparam logic [ACT_BITS-1:0] ACT_CROSS     = 4'd3;
  localparam logic [ACT_BITS-1:0] ACT_SCALE     = 4'd4;
  localparam logic [ACT_BITS-1:0] ACT_LENGTH    = 4'd5;
  localparam logic [ACT_BITS-1:0] ACT_NORMALIZE = 4'd6;
  localparam logic [ACT_BITS-1:0] ACT_ROTX      = 4'd7;
  localparam logic [ACT_BITS-1:0] ACT_ROTY      = 4'd8;
  localparam logic [ACT_BITS-1:0] ACT_ROTZ      = 4'd9;

  // Angle arithmetic is done in Q2.30 radians.
  localparam int TRIG_FRAC = 30;
  localparam int TRIG_BITS = TRIG_FRAC + 5;
  localparam int ANG_BITS  = WORD_BITS + TRIG_FRAC - FRAC_BITS;
  localparam int MOD_STEPS = (ANG_BITS > 33) ? ANG_BITS - 32 : 1;
  localparam int MOD_BITS  = ANG_BITS + MOD_STEPS + 34;

  localparam longint PI_VAL      = 64'sd3373259426;
  localparam longint HALF_PI_VAL = PI_VAL / 2;
  localparam longint TWO_PI_VAL  = 2 * PI_VAL;
  localparam longint KINV_VAL    = 64'sd652032874;

  // Arctangent of 2^-i in Q2.30.
  localparam logic [31:0] ATAN_Q30 [0:31] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  // Square root and division.
  localparam int SQRT_STEPS = WORD_BITS;
  localparam int SQ_BITS    = 2 * WORD_BITS;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DVD_BITS   = WORD_BITS + FRAC_BITS;

  // Pipeline depths of the long units.
  localparam int TRIG_LAT  = 1 + MOD_STEPS + 2 + TRIG_ITERATIONS + 1;
  localparam int NORM_LAT  = 2 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int ALIGN_LAT = (TRIG_LAT > NORM_LAT) ? TRIG_LAT : NORM_LAT;

  // Lane arithmetic widths.
  localparam int MUL_BITS  = (TRIG_BITS > WORD_BITS + 1) ? TRIG_BITS : WORD_BITS + 1;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int WIDE_BITS = PROD_BITS + 1;
  localparam int MRG_BITS  = WIDE_BITS + 2;
  localparam int NV_BITS   = WORD_BITS + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [MUL_BITS-1:0]  mul_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic signed [NV_BITS-1:0]   nv_t;
  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } sc_t;

  typedef struct packed {
    logic [ACT_BITS-1:0] act;
    word_t               ax;
    word_t               ay;
    word_t               az;
    word_t               bx;
    word_t               by;
    word_t               bz;
  } item_t;

endpackage

/* rtl/v3u_sincos.sv */
// Pipelined sine and cosine: angle reduction followed by CORDIC rotation.
module v3u_sincos (
  input  logic             clk,
  input  v3u_pkg::word_t   ang,
  output v3u_pkg::sc_t     sc
);

  localparam int AB = v3u_pkg::ANG_BITS;
  localparam int MS = v3u_pkg::MOD_STEPS;
  localparam int MB = v3u_pkg::MOD_BITS;
  localparam int TB = v3u_pkg::TRIG_BITS;
  localparam int TI = v3u_pkg::TRIG_ITERATIONS;

  logic signed [AB-1:0] ang_s;
  logic [AB-1:0]        mag [0:MS];
  logic                 sgn [0:MS];
  logic signed [TB-1:0] m_w;
  logic signed [TB-1:0] w_v;
  logic signed [TB-1:0] r_w;
  logic                 s_w;
  logic signed [TB-1:0] r_h;
  logic                 n_h;
  logic signed [TB-1:0] x [0:TI-1];
  logic signed [TB-1:0] y [0:TI-1];
  logic signed [TB-1:0] r [0:TI-1];
  logic                 ng [0:TI-1];

  // Angle moved to Q2.30.
  assign ang_s = AB'(ang) <<< (v3u_pkg::TRIG_FRAC - v3u_pkg::FRAC_BITS);

  // Split the angle into sign and magnitude.
  always_ff @(posedge clk) begin
    mag[0] <= ang_s[AB-1] ? AB'(-ang_s) : AB'(ang_s);
    sgn[0] <= ang_s[AB-1];
  end

  // Remainder by two pi: each stage subtracts one power-of-two multiple of two pi, largest first.
  for (genvar j = 0; j < MS; j++) begin : g_mod
    logic [MB-1:0] cmp;
    assign cmp = MB'(v3u_pkg::TWO_PI_VAL) << (MS - 1 - j);
    always_ff @(posedge clk) begin
      if (MB'(mag[j]) >= cmp) begin
        mag[j+1] <= mag[j] - AB'(cmp);
      end else begin
        mag[j+1] <= mag[j];
      end
      sgn[j+1] <= sgn[j];
    end
  end

  // Wrap into minus pi to pi and restore the sign.
  assign m_w = TB'(mag[MS]);
  assign w_v = (m_w > TB'(v3u_pkg::PI_VAL)) ? m_w - TB'(v3u_pkg::TWO_PI_VAL) : m_w;

  always_ff @(posedge clk) begin
    r_w <= sgn[MS] ? -w_v : w_v;
  end

  // Fold into the right half plane and remember the sign flip.
  always_ff @(posedge clk) begin
    if (r_w > TB'(v3u_pkg::HALF_PI_VAL)) begin
      r_h <= r_w - TB'(v3u_pkg::PI_VAL);
      n_h <= 1'b1;
    end else if (r_w < -TB'(v3u_pkg::HALF_PI_VAL)) begin
      r_h <= r_w + TB'(v3u_pkg::PI_VAL);
      n_h <= 1'b1;
    end else begin
      r_h <= r_w;
      n_h <= 1'b0;
    end
  end
  assign s_w = n_h;

  // CORDIC iterations, one per stage.
  for (genvar i = 0; i < TI; i++) begin : g_cordic
    logic signed [TB-1:0] xi;
    logic signed [TB-1:0] yi;
    logic signed [TB-1:0] ri;
    logic                 ni;
    logic signed [TB-1:0] at;
    if (i == 0) begin : g_first
      assign xi = TB'(v3u_pkg::KINV_VAL);
      assign yi = '0;
      assign ri = r_h;
      assign ni = s_w;
    end else begin : g_next
      assign xi = x[i-1];
      assign yi = y[i-1];
      assign ri = r[i-1];
      assign ni = ng[i-1];
    end
    assign at = TB'(v3u_pkg::ATAN_Q30[i]);
    always_ff @(posedge clk) begin
      if (ri >= 0) begin
        x[i] <= xi - (yi >>> i);
        y[i] <= yi + (xi >>> i);
        r[i] <= ri - at;
      end else begin
        x[i] <= xi + (yi >>> i);
        y[i] <= yi - (xi >>> i);
        r[i] <= ri + at;
      end
      ng[i] <= ni;
    end
  end

  // Undo the half-plane fold.
  always_ff @(posedge clk) begin
    sc.c <= ng[TI-1] ? -x[TI-1] : x[TI-1];
    sc.s <= ng[TI-1] ? -y[TI-1] : y[TI-1];
  end

endmodule

/* rtl/v3u_div.sv */
// One division lane: restoring divide of a magnitude by the length.
module v3u_div (
  input  logic                              clk,
  input  logic [v3u_pkg::DVD_BITS-1:0]      dvd,
  input  logic                              neg,
  input  logic [v3u_pkg::WORD_BITS-1:0]     dsr,
  output v3u_pkg::word_t                    quo
);

  localparam int DS = v3u_pkg::DIV_STEPS;
  localparam int DB = v3u_pkg::DVD_BITS;
  localparam int W  = v3u_pkg::WORD_BITS;
  localparam int CB = W + DS;

  logic [DB-1:0] rem [0:DS-1];
  logic [DS-1:0] qb  [0:DS-1];
  logic [W-1:0]  d   [0:DS-1];
  logic          ng  [0:DS-1];
  v3u_pkg::word_t qw;

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < DS; j++) begin : g_step
    logic [DB-1:0] ri;
    logic [DS-1:0] qi;
    logic [W-1:0]  di;
    logic          ni;
    logic [CB-1:0] cmp;
    if (j == 0) begin : g_first
      assign ri = dvd;
      assign qi = '0;
      assign di = dsr;
      assign ni = neg;
    end else begin : g_next
      assign ri = rem[j-1];
      assign qi = qb[j-1];
      assign di = d[j-1];
      assign ni = ng[j-1];
    end
    assign cmp = CB'(di) << (DS - 1 - j);
    always_ff @(posedge clk) begin
      if (CB'(ri) >= cmp) begin
        rem[j] <= ri - DB'(cmp);
        qb[j]  <= qi | (DS'(1) << (DS - 1 - j));
      end else begin
        rem[j] <= ri;
        qb[j]  <= qi;
      end
      d[j]  <= di;
      ng[j] <= ni;
    end
  end

  assign qw = W'(qb[DS-1]);

  // Apply the sign; a zero length gives a zero result.
  always_ff @(posedge clk) begin
    if (d[DS-1] == '0) begin
      quo <= '0;
    end else begin
      quo <= ng[DS-1] ? -qw : qw;
    end
  end

endmodule

/* rtl/v3u_norm.sv */
// Length of vector a by a bitwise square root, then three division lanes.
module v3u_norm (
  input  logic                          clk,
  input  v3u_pkg::word_t                ax,
  input  v3u_pkg::word_t                ay,
  input  v3u_pkg::word_t                az,
  output logic [v3u_pkg::WORD_BITS-1:0] len,
  output v3u_pkg::word_t                qx,
  output v3u_pkg::word_t                qy,
  output v3u_pkg::word_t                qz
);

  localparam int W  = v3u_pkg::WORD_BITS;
  localparam int F  = v3u_pkg::FRAC_BITS;
  localparam int SB = v3u_pkg::SQ_BITS;
  localparam int SS = v3u_pkg::SQRT_STEPS;
  localparam int DS = v3u_pkg::DIV_STEPS;

  v3u_pkg::word_t       a_in [0:2];
  logic [SB-1:0]        sq   [0:2];
  logic [SB-1:0]        sum;
  logic [2:0][W-1:0]    mg   [0:SS+1];
  logic [2:0]           sg   [0:SS+1];
  logic [SB-1:0]        n    [0:SS-1];
  logic [SB-1:0]        res  [0:SS-1];
  logic [W-1:0]         len_s;
  logic [W-1:0]         ld   [0:DS+1];
  v3u_pkg::word_t       q    [0:2];

  assign a_in[0] = ax;
  assign a_in[1] = ay;
  assign a_in[2] = az;

  // Squares, magnitudes and signs of the components.
  for (genvar c = 0; c < 3; c++) begin : g_sq
    always_ff @(posedge clk) begin
      sq[c]    <= SB'(SB'(a_in[c]) * SB'(a_in[c]));
      mg[0][c] <= a_in[c][W-1] ? W'(-a_in[c]) : W'(a_in[c]);
      sg[0][c] <= a_in[c][W-1];
    end
  end

  // Sum of squares.
  always_ff @(posedge clk) begin
    sum   <= sq[0] + sq[1] + sq[2];
    mg[1] <= mg[0];
    sg[1] <= sg[0];
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    logic [SB-1:0] ni;
    logic [SB-1:0] ri;
    logic [SB-1:0] bt;
    logic [SB-1:0] tr;
    if (k == 0) begin : g_first
      assign ni = sum;
      assign ri = '0;
    end else begin : g_next
      assign ni = n[k-1];
      assign ri = res[k-1];
    end
    assign bt = SB'(1) << (SB - 2 - 2 * k);
    assign tr = ri + bt;
    always_ff @(posedge clk) begin
      if (ni >= tr) begin
        n[k]   <= ni - tr;
        res[k] <= (ri >> 1) + bt;
      end else begin
        n[k]   <= ni;
        res[k] <= ri >> 1;
      end
      mg[k+2] <= mg[k+1];
      sg[k+2] <= sg[k+1];
    end
  end

  assign len_s = res[SS-1][W-1:0];

  // Division lanes, one per component.
  for (genvar c = 0; c < 3; c++) begin : g_div
    v3u_div u_div (
      .clk (clk),
      .dvd ({mg[SS+1][c], {F{1'b0}}}),
      .neg (sg[SS+1][c]),
      .dsr (len_s),
      .quo (q[c])
    );
  end

  // Length delayed to meet the quotients.
  assign ld[0] = len_s;
  for (genvar j = 0; j < DS + 1; j++) begin : g_ld
    always_ff @(posedge clk) begin
      ld[j+1] <= ld[j];
    end
  end

  assign len = ld[DS+1];
  assign qx  = q[0];
  assign qy  = q[1];
  assign qz  = q[2];

endmodule

/* rtl/v3u_lane.sv */
// One component lane: two multipliers, then the per-operation combine.
module v3u_lane (
  input  logic                             clk,
  input  logic [v3u_pkg::ACT_BITS-1:0]     act,
  input  v3u_pkg::word_t                   ai,
  input  v3u_pkg::word_t                   bi,
  input  v3u_pkg::mul_t                    m0a,
  input  v3u_pkg::mul_t                    m0b,
  input  v3u_pkg::mul_t                    m1a,
  input  v3u_pkg::mul_t                    m1b,
  input  v3u_pkg::nv_t                     nv,
  output v3u_pkg::wide_t                   res
);

  localparam int PB = v3u_pkg::PROD_BITS;
  localparam int WB = v3u_pkg::WIDE_BITS;

  logic signed [PB-1:0]          p0;
  logic signed [PB-1:0]          p1;
  v3u_pkg::word_t                a1;
  v3u_pkg::word_t                b1;
  v3u_pkg::nv_t                  nv1;
  logic [v3u_pkg::ACT_BITS-1:0]  act1;
  v3u_pkg::wide_t                fp0;
  v3u_pkg::wide_t                fp1;
  v3u_pkg::wide_t                rsum;

  // Products.
  always_ff @(posedge clk) begin
    p0   <= m0a * m0b;
    p1   <= m1a * m1b;
    a1   <= ai;
    b1   <= bi;
    nv1  <= nv;
    act1 <= act;
  end

  assign fp0  = WB'(p0 >>> v3u_pkg::FRAC_BITS);
  assign fp1  = WB'(p1 >>> v3u_pkg::FRAC_BITS);
  assign rsum = (WB'(p0) + WB'(p1)) >>> v3u_pkg::TRIG_FRAC;

  // Combine by operation.
  always_ff @(posedge clk) begin
    case (act1)
      v3u_pkg::ACT_ADD:       res <= WB'(a1) + WB'(b1);
      v3u_pkg::ACT_SUB:       res <= WB'(a1) - WB'(b1);
      v3u_pkg::ACT_DOT:       res <= fp0;
      v3u_pkg::ACT_SCALE:     res <= fp0;
      v3u_pkg::ACT_CROSS:     res <= fp0 - fp1;
      v3u_pkg::ACT_LENGTH:    res <= WB'(nv1);
      v3u_pkg::ACT_NORMALIZE: res <= WB'(nv1);
      v3u_pkg::ACT_ROTX:      res <= rsum;
      v3u_pkg::ACT_ROTY:      res <= rsum;
      v3u_pkg::ACT_ROTZ:      res <= rsum;
      default:                res <= '0;
    endcase
  end

endmodule

/* rtl/vec3_vector_unit.sv */
// Channel  | Ports                                  | Handshake
// request  | action, a_x, a_y, a_z, b_x, b_y, b_z   | start high, busy low
// result   | r_x, r_y, r_z, overflow                | done high for one cycle
//
// A new request is taken in every cycle; busy is never raised.
// Each result is on the ports while done is high and is taken at the following
// edge; the pipeline depth is set by the square root and division pipeline of
// the normalize path.
// Requests come out in order; all operations share the same latency.
// Reset clears the valid pipeline only; no clearing pass is needed.
module vec3_vector_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [v3u_pkg::ACT_BITS-1:0]     action,
  input  v3u_pkg::word_t                   a_x,
  input  v3u_pkg::word_t                   a_y,
  input  v3u_pkg::word_t                   a_z,
  input  v3u_pkg::word_t                   b_x,
  input  v3u_pkg::word_t                   b_y,
  input  v3u_pkg::word_t                   b_z,
  output logic                             done,
  output v3u_pkg::word_t                   r_x,
  output v3u_pkg::word_t                   r_y,
  output v3u_pkg::word_t                   r_z,
  output logic                             overflow
);

  localparam int AL   = v3u_pkg::ALIGN_LAT;
  localparam int TD   = AL - v3u_pkg::TRIG_LAT;
  localparam int ND   = AL - v3u_pkg::NORM_LAT;
  localparam int PIPE = AL + 5;
  localparam int W    = v3u_pkg::WORD_BITS;
  localparam int MB   = v3u_pkg::MUL_BITS;
  localparam int RB   = v3u_pkg::MRG_BITS;

  typedef struct packed {
    logic [W-1:0]   len;
    v3u_pkg::word_t qx;
    v3u_pkg::word_t qy;
    v3u_pkg::word_t qz;
  } norm_t;

  logic [PIPE-1:0]               vpipe;
  v3u_pkg::item_t                in_r;
  v3u_pkg::item_t                idl [0:AL];
  v3u_pkg::sc_t                  sc_u;
  v3u_pkg::sc_t                  tdl [0:TD];
  norm_t                         nrm_u;
  norm_t                         ndl [0:ND];
  v3u_pkg::item_t                al;
  v3u_pkg::sc_t                  sca;
  norm_t                         nra;
  v3u_pkg::mul_t                 cc;
  v3u_pkg::mul_t                 ss;
  v3u_pkg::mul_t                 one;
  v3u_pkg::mul_t                 ax_m, ay_m, az_m, bx_m, by_m, bz_m;
  v3u_pkg::mul_t                 m0a [0:2];
  v3u_pkg::mul_t                 m0b [0:2];
  v3u_pkg::mul_t                 m1a [0:2];
  v3u_pkg::mul_t                 m1b [0:2];
  v3u_pkg::nv_t                  nv  [0:2];
  v3u_pkg::word_t                ai  [0:2];
  v3u_pkg::word_t                bi  [0:2];
  v3u_pkg::wide_t                lres [0:2];
  logic [v3u_pkg::ACT_BITS-1:0]  act_l1;
  logic [v3u_pkg::ACT_BITS-1:0]  act_l2;
  logic [v3u_pkg::ACT_BITS-1:0]  act_m;
  logic [v3u_pkg::ACT_BITS-1:0]  act_o;
  logic signed [RB-1:0]          mrg  [0:2];
  logic signed [RB-1:0]          wmax;
  logic signed [RB-1:0]          wmin;
  v3u_pkg::word_t                sat  [0:2];
  logic [2:0]                    ovc;

  assign busy = 1'b0;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE-2:0], start & ~busy};
    end
  end
  assign done = vpipe[PIPE-1];

  // Request register.
  always_ff @(posedge clk) begin
    in_r <= '{act: action, ax: a_x, ay: a_y, az: a_z, bx: b_x, by: b_y, bz: b_z};
  end

  // Long units.
  v3u_sincos u_sincos (
    .clk (clk),
    .ang (in_r.bx),
    .sc  (sc_u)
  );

  v3u_norm u_norm (
    .clk (clk),
    .ax  (in_r.ax),
    .ay  (in_r.ay),
    .az  (in_r.az),
    .len (nrm_u.len),
    .qx  (nrm_u.qx),
    .qy  (nrm_u.qy),
    .qz  (nrm_u.qz)
  );

  // Delay lines that bring everything to the same stage.
  assign idl[0] = in_r;
  for (genvar k = 0; k < AL; k++) begin : g_idl
    always_ff @(posedge clk) begin
      idl[k+1] <= idl[k];
    end
  end

  assign tdl[0] = sc_u;
  for (genvar k = 0; k < TD; k++) begin : g_tdl
    always_ff @(posedge clk) begin
      tdl[k+1] <= tdl[k];
    end
  end

  assign ndl[0] = nrm_u;
  for (genvar k = 0; k < ND; k++) begin : g_ndl
    always_ff @(posedge clk) begin
      ndl[k+1] <= ndl[k];
    end
  end

  assign al  = idl[AL];
  assign sca = tdl[TD];
  assign nra = ndl[ND];

  assign cc   = MB'(sca.c);
  assign ss   = MB'(sca.s);
  assign one  = MB'(1) <<< v3u_pkg::TRIG_FRAC;
  assign ax_m = MB'(al.ax);
  assign ay_m = MB'(al.ay);
  assign az_m = MB'(al.az);
  assign bx_m = MB'(al.bx);
  assign by_m = MB'(al.by);
  assign bz_m = MB'(al.bz);

  assign ai[0] = al.ax;
  assign ai[1] = al.ay;
  assign ai[2] = al.az;
  assign bi[0] = al.bx;
  assign bi[1] = al.by;
  assign bi[2] = al.bz;

  // Operand selection for the three lanes.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      m0a[l] = '0;
      m0b[l] = '0;
      m1a[l] = '0;
      m1b[l] = '0;
      nv[l]  = '0;
    end
    case (al.act)
      v3u_pkg::ACT_DOT: begin
        m0a[0] = ax_m; m0b[0] = bx_m;
        m0a[1] = ay_m; m0b[1] = by_m;
        m0a[2] = az_m; m0b[2] = bz_m;
      end
      v3u_pkg::ACT_CROSS: begin
        m0a[0] = ay_m; m0b[0] = bz_m; m1a[0] = az_m; m1b[0] = by_m;
        m0a[1] = az_m; m0b[1] = bx_m; m1a[1] = ax_m; m1b[1] = bz_m;
        m0a[2] = ax_m; m0b[2] = by_m; m1a[2] = ay_m; m1b[2] = bx_m;
      end
      v3u_pkg::ACT_SCALE: begin
        m0a[0] = ax_m; m0b[0] = bx_m;
        m0a[1] = ay_m; m0b[1] = bx_m;
        m0a[2] = az_m; m0b[2] = bx_m;
      end
      v3u_pkg::ACT_LENGTH: begin
        nv[0] = v3u_pkg::NV_BITS'(nra.len);
      end
      v3u_pkg::ACT_NORMALIZE: begin
        nv[0] = v3u_pkg::NV_BITS'(nra.qx);
        nv[1] = v3u_pkg::NV_BITS'(nra.qy);
        nv[2] = v3u_pkg::NV_BITS'(nra.qz);
      end
      v3u_pkg::ACT_ROTX: begin
        m0a[0] = ax_m; m0b[0] = one;
        m0a[1] = ay_m; m0b[1] = cc; m1a[1] = az_m; m1b[1] = -ss;
        m0a[2] = ay_m; m0b[2] = ss; m1a[2] = az_m; m1b[2] = cc;
      end
      v3u_pkg::ACT_ROTY: begin
        m0a[0] = ax_m; m0b[0] = cc; m1a[0] = az_m; m1b[0] = ss;
        m0a[1] = ay_m; m0b[1] = one;
        m0a[2] = az_m; m0b[2] = cc; m1a[2] = ax_m; m1b[2] = -ss;
      end
      v3u_pkg::ACT_ROTZ: begin
        m0a[0] = ax_m; m0b[0] = cc; m1a[0] = ay_m; m1b[0] = -ss;
        m0a[1] = ax_m; m0b[1] = ss; m1a[1] = ay_m; m1b[1] = cc;
        m0a[2] = az_m; m0b[2] = one;
      end
      default: begin
      end
    endcase
  end

  // Component lanes.
  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3u_lane u_lane (
      .clk (clk),
      .act (al.act),
      .ai  (ai[l]),
      .bi  (bi[l]),
      .m0a (m0a[l]),
      .m0b (m0b[l]),
      .m1a (m1a[l]),
      .m1b (m1b[l]),
      .nv  (nv[l]),
      .res (lres[l])
    );
  end

  always_ff @(posedge clk) begin
    act_l1 <= al.act;
    act_l2 <= act_l1;
  end

  // Merge: the dot product sums the three lanes into x.
  always_ff @(posedge clk) begin
    if (act_l2 == v3u_pkg::ACT_DOT) begin
      mrg[0] <= RB'(lres[0]) + RB'(lres[1]) + RB'(lres[2]);
      mrg[1] <= '0;
      mrg[2] <= '0;
    end else begin
      mrg[0] <= RB'(lres[0]);
      mrg[1] <= RB'(lres[1]);
      mrg[2] <= RB'(lres[2]);
    end
    act_m <= act_l2;
  end

  // Saturation to the word range.
  assign wmax = {{(RB-W+1){1'b0}}, {(W-1){1'b1}}};
  assign wmin = ~wmax;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (mrg[l] > wmax) begin
        sat[l] = W'(wmax);
        ovc[l] = 1'b1;
      end else if (mrg[l] < wmin) begin
        sat[l] = W'(wmin);
        ovc[l] = 1'b1;
      end else begin
        sat[l] = W'(mrg[l]);
        ovc[l] = 1'b0;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    r_x      <= sat[0];
    r_y      <= sat[1];
    r_z      <= sat[2];
    overflow <= |ovc;
    act_o    <= act_m;
  end

  // Every result traces back to an accepted request.
  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE))
    else $error("result without a request");

  // Normalized components never saturate.
  a_norm_ov: assert property (@(posedge clk) disable iff (rst)
    (done && act_o == v3u_pkg::ACT_NORMALIZE) |-> !overflow)
    else $error("normalize raised overflow");

  // Scalar results leave y and z at zero.
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    (done && (act_o == v3u_pkg::ACT_DOT || act_o == v3u_pkg::ACT_LENGTH))
      |-> (r_y == '0 && r_z == '0))
    else $error("scalar result with nonzero y or z");

  // Unused codes give an all-zero result.
  a_unused: assert property (@(posedge clk) disable iff (rst)
    (done && act_o > v3u_pkg::ACT_ROTZ)
      |-> (r_x == '0 && r_y == '0 && r_z == '0 && !overflow))
    else $error("unused action gave a nonzero result");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import v3u_pkg::*;

  // One predicted result of the vector unit.
  typedef struct {
    word_t rx;
    word_t ry;
    word_t rz;
    logic  ov;
  } vres_t;

  localparam int LATENCY = ALIGN_LAT + 5;

  // Scoreboard: predicts each request and checks results in order.
  class vec_scoreboard;
    vres_t pending[$];
    int    mismatches;
    int    checked;
    int    op_count[16];

    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint fx_mul(longint a, longint b);
      return floor_shift(a * b, FRAC_BITS);
    endfunction

    function longint clamp_word(longint v, ref logic ov);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        ov = 1'b1;
        return hi;
      end
      if (v < lo) begin
        ov = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // CORDIC sine and cosine in Q2.30 of an angle in Q16.16 radians.
    function void sin_cos(longint ang, output longint c, output longint s);
      longint r;
      longint x;
      longint y;
      longint t;
      bit     flip;
      r = ang * (longint'(1) <<< (TRIG_FRAC - FRAC_BITS));
      x = KINV_VAL;
      y = 0;
      flip = 0;
      r = r % TWO_PI_VAL;
      if (r > PI_VAL) r -= TWO_PI_VAL;
      if (r < -PI_VAL) r += TWO_PI_VAL;
      if (r > HALF_PI_VAL) begin
        r -= PI_VAL;
        flip = 1;
      end else if (r < -HALF_PI_VAL) begin
        r += PI_VAL;
        flip = 1;
      end
      for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
        if (r >= 0) begin
          t = x - floor_shift(y, i);
          y = y + floor_shift(x, i);
          r -= longint'(ATAN_Q30[i]);
        end else begin
          t = x + floor_shift(y, i);
          y = y - floor_shift(x, i);
          r += longint'(ATAN_Q30[i]);
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // Note an accepted request and queue its expected result.
    function void note_request(item_t it);
      longint ax, ay, az, bx, by, bz, rx, ry, rz, c, s;
      longint unsigned sq, len;
      vres_t e;
      ax = it.ax; ay = it.ay; az = it.az;
      bx = it.bx; by = it.by; bz = it.bz;
      rx = 0; ry = 0; rz = 0;
      e.ov = 1'b0;
      op_count[it.act]++;
      case (it.act)
        ACT_ADD: begin
          rx = ax + bx; ry = ay + by; rz = az + bz;
        end
        ACT_SUB: begin
          rx = ax - bx; ry = ay - by; rz = az - bz;
        end
        ACT_DOT: rx = fx_mul(ax, bx) + fx_mul(ay, by) + fx_mul(az, bz);
        ACT_CROSS: begin
          rx = fx_mul(ay, bz) - fx_mul(az, by);
          ry = fx_mul(az, bx) - fx_mul(ax, bz);
          rz = fx_mul(ax, by) - fx_mul(ay, bx);
        end
        ACT_SCALE: begin
          rx = fx_mul(ax, bx); ry = fx_mul(ay, bx); rz = fx_mul(az, bx);
        end
        ACT_LENGTH, ACT_NORMALIZE: begin
          sq = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
          len = int_sqrt(sq);
          if (it.act == ACT_LENGTH) begin
            rx = len;
          end else if (len != 0) begin
            rx = (ax * (longint'(1) <<< FRAC_BITS)) / longint'(len);
            ry = (ay * (longint'(1) <<< FRAC_BITS)) / longint'(len);
            rz = (az * (longint'(1) <<< FRAC_BITS)) / longint'(len);
          end
        end
        ACT_ROTX: begin
          sin_cos(bx, c, s);
          rx = ax;
          ry = floor_shift(ay * c - az * s, TRIG_FRAC);
          rz = floor_shift(ay * s + az * c, TRIG_FRAC);
        end
        ACT_ROTY: begin
          sin_cos(bx, c, s);
          rx = floor_shift(ax * c + az * s, TRIG_FRAC);
          ry = ay;
          rz = floor_shift(az * c - ax * s, TRIG_FRAC);
        end
        ACT_ROTZ: begin
          sin_cos(bx, c, s);
          rx = floor_shift(ax * c - ay * s, TRIG_FRAC);
          ry = floor_shift(ax * s + ay * c, TRIG_FRAC);
          rz = az;
        end
        default: ;
      endcase
      e.rx = word_t'(clamp_word(rx, e.ov));
      e.ry = word_t'(clamp_word(ry, e.ov));
      e.rz = word_t'(clamp_word(rz, e.ov));
      pending.push_back(e);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(word_t rx, word_t ry, word_t rz, logic ov);
      vres_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result %h %h %h ov=%b", rx, ry, rz, ov);
        return;
      end
      e = pending.pop_front();
      if (rx !== e.rx || ry !== e.ry || rz !== e.rz || ov !== e.ov) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp %h %h %h ov=%b got %h %h %h ov=%b",
                   checked, e.rx, e.ry, e.rz, e.ov, rx, ry, rz, ov);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACT_BITS-1:0] action;
  word_t               a_x, a_y, a_z, b_x, b_y, b_z;
  logic                done;
  word_t               r_x, r_y, r_z;
  logic                overflow;

  vec_scoreboard board;
  bit            calm;

  vec3_vector_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung run.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(r_x, r_y, r_z, overflow);
  end

  // Present one request, idling at random first, and wait for it to be taken.
  task automatic send_request(item_t it);
    while (!calm && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    action <= it.act;
    a_x <= it.ax; a_y <= it.ay; a_z <= it.az;
    b_x <= it.bx; b_y <= it.by; b_z <= it.bz;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(it);
  endtask

  // Random component: mostly modest values, sometimes the full range.
  function automatic word_t rand_word();
    case ($urandom_range(3))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      2: return word_t'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
      default: return word_t'($signed($urandom_range(32'h0000_4000)) - 32'sh0000_2000);
    endcase
  endfunction

  function automatic item_t rand_request();
    item_t it;
    it.act = ($urandom_range(19) == 0) ? ACT_BITS'($urandom_range(15, 10))
                                       : ACT_BITS'($urandom_range(9));
    it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
    it.bx = rand_word(); it.by = rand_word(); it.bz = rand_word();
    return it;
  endfunction

  initial begin
    item_t it;
    word_t edges [4];
    int    waited;
    board = new();
    calm = 0;
    rst = 1'b1; start = 1'b0; action = '0;
    a_x = '0; a_y = '0; a_z = '0; b_x = '0; b_y = '0; b_z = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    edges = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 32'sh0};

    // Directed: every operation at the extremes, zero-vector normalize, and
    // unused action codes.
    for (int op = 0; op < 10; op++) begin
      it.act = ACT_BITS'(op);
      it.ax = edges[op % 4]; it.ay = edges[(op + 1) % 4]; it.az = edges[(op + 2) % 4];
      it.bx = edges[(op + 3) % 4]; it.by = edges[op % 4]; it.bz = edges[(op + 1) % 4];
      send_request(it);
    end
    it = '{act: ACT_NORMALIZE, ax: 0, ay: 0, az: 0, bx: 5, by: 6, bz: 7};
    send_request(it);
    it = '{act: ACT_LENGTH, ax: 32'sh8000_0000, ay: 32'sh8000_0000,
           az: 32'sh8000_0000, bx: 0, by: 0, bz: 0};
    send_request(it);
    it = '{act: ACT_ROTZ, ax: 32'sh0001_0000, ay: 0, az: 0,
           bx: 32'sh7fff_ffff, by: 0, bz: 0};
    send_request(it);
    it = '{act: ACT_ROTY, ax: 32'sh0001_0000, ay: 0, az: 32'sh0002_0000,
           bx: 32'sh8000_0000, by: 0, bz: 0};
    send_request(it);
    it = '{act: ACT_ROTX, ax: 1, ay: 32'sh0001_0000, az: 0,
           bx: 32'sh0001_921f, by: 0, bz: 0};
    send_request(it);
    it = '{act: 4'd15, ax: -1, ay: -1, az: -1, bx: -1, by: -1, bz: -1};
    send_request(it);
    it = '{act: 4'd10, ax: 1, ay: 2, az: 3, bx: 4, by: 5, bz: 6};
    send_request(it);

    // Random requests, with a long stretch of back-to-back traffic.
    for (int n = 0; n < 1700; n++) begin
      calm = (n >= 600 && n < 900);
      send_request(rand_request());
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a little extra for stray strobes.
    waited = 0;
    while (board.pending.size() != 0 && waited < 20 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    if (board.pending.size() != 0) begin
      $display("Regression FAIL");
      $finish;
    end
    repeat (LATENCY + 5) @(posedge clk);

    $display("Covered %0d results across all ten operations and the unused codes",
             board.checked);
    $display("(add %0d, normalize %0d, rotz %0d), with random request gaps.",
             board.op_count[0], board.op_count[6], board.op_count[9]);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
